// ===== design/wmtd_pkg.sv =====
package wmtd_pkg;

    // Widths fixed by the register map and the item fields.
    localparam int THR_W       = 8;
    localparam int SIZE_W      = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_PIX_W    = 8;

    // Row position and the largest frame height that the counters cover.
    localparam int ROW_W       = 10;
    localparam int LIMIT_POS   = 1024;
    localparam int MIN_SIZE    = 3;

    // Reset values of the registers.
    localparam logic [THR_W-1:0]  THR_RESET  = 8'd10;
    localparam logic [SIZE_W-1:0] ROWS_RESET = 11'd10;
    localparam logic [SIZE_W-1:0] COLS_RESET = 11'd30;

    // Default parameter values.
    localparam int MAX_COLS_DEFAULT   = 1024;
    localparam int PIXEL_BITS_DEFAULT = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STAR_THRESHOLD = 2'd0,
        REG_ROW_COUNT      = 2'd1,
        REG_COLUMN_COUNT   = 2'd2
    } cfg_reg_t;

    // What the scan position says about the item just accepted.
    typedef struct packed {
        logic produce;
        logic row_end;
        logic frame_end;
    } scan_info_t;

endpackage

// ===== design/wmtd_line_ram.sv =====
module wmtd_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/wmtd_scan.sv =====
module wmtd_scan #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [wmtd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wmtd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 advance,
    output logic [AW-1:0]                        col_addr,
    output wmtd_pkg::scan_info_t                 info,
    output logic [wmtd_pkg::THR_W-1:0]           threshold
);

    localparam int CW = AW + 1;
    localparam logic [CW-1:0] COL_MIN = CW'(wmtd_pkg::MIN_SIZE);
    localparam logic [CW-1:0] COL_MAX = CW'(DEPTH);
    localparam logic [wmtd_pkg::SIZE_W-1:0] ROW_MIN = wmtd_pkg::SIZE_W'(wmtd_pkg::MIN_SIZE);
    localparam logic [wmtd_pkg::SIZE_W-1:0] ROW_MAX = wmtd_pkg::SIZE_W'(wmtd_pkg::LIMIT_POS);
    localparam logic [wmtd_pkg::SIZE_W-1:0] COL_MAX_WIDE = wmtd_pkg::SIZE_W'(DEPTH);

    logic [wmtd_pkg::THR_W-1:0]  thr_reg,  thr_next;
    logic [wmtd_pkg::SIZE_W-1:0] rows_reg, rows_next;
    logic [wmtd_pkg::SIZE_W-1:0] cols_reg, cols_next;
    logic [wmtd_pkg::ROW_W-1:0]  row_reg,  row_next;
    logic [AW-1:0]               col_reg,  col_next;

    logic [wmtd_pkg::SIZE_W-1:0] rows_use;
    logic [CW-1:0]               cols_use;
    logic [CW-1:0]               col_inc;
    logic [wmtd_pkg::SIZE_W-1:0] row_inc;
    logic                        last_col;
    logic                        last_row;

    // Sizes outside the supported range are clamped.
    always_comb
    begin
        priority if (rows_reg < ROW_MIN)
        begin
            rows_use = ROW_MIN;
        end
        else if (rows_reg > ROW_MAX)
        begin
            rows_use = ROW_MAX;
        end
        else
        begin
            rows_use = rows_reg;
        end

        priority if (cols_reg < wmtd_pkg::SIZE_W'(COL_MIN))
        begin
            cols_use = COL_MIN;
        end
        else if (cols_reg > COL_MAX_WIDE)
        begin
            cols_use = COL_MAX;
        end
        else
        begin
            cols_use = cols_reg[CW-1:0];
        end
    end

    assign col_inc  = {1'b0, col_reg} + CW'(1);
    assign row_inc  = {1'b0, row_reg} + wmtd_pkg::SIZE_W'(1);
    assign last_col = (col_inc >= cols_use);
    assign last_row = (row_inc >= rows_use);

    always_comb
    begin
        thr_next  = thr_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        row_next  = row_reg;
        col_next  = col_reg;

        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[wmtd_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end

        // A size write restarts the frame; the user must write only while idle, which the block does not enforce.
        if (cfg_write)
        begin
            unique case (cfg_index)
                wmtd_pkg::REG_STAR_THRESHOLD:
                begin
                    thr_next = cfg_data[wmtd_pkg::THR_W-1:0];
                end
                wmtd_pkg::REG_ROW_COUNT:
                begin
                    rows_next = cfg_data;
                    row_next  = '0;
                    col_next  = '0;
                end
                wmtd_pkg::REG_COLUMN_COUNT:
                begin
                    cols_next = cfg_data;
                    row_next  = '0;
                    col_next  = '0;
                end
                default:
                begin
                    thr_next = thr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= wmtd_pkg::THR_RESET;
            rows_reg <= wmtd_pkg::ROWS_RESET;
            cols_reg <= wmtd_pkg::COLS_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            thr_reg  <= thr_next;
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    // The window is complete once two rows and two columns have passed.
    assign info.produce   = (row_reg >= wmtd_pkg::ROW_W'(2)) && (col_reg >= AW'(2));
    assign info.row_end   = last_col;
    assign info.frame_end = last_col && last_row;

    assign col_addr  = col_reg;
    assign threshold = thr_reg;

endmodule

// ===== design/wmtd_window.sv =====
module wmtd_window #(
    parameter int PW = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [PW-1:0]                  top,
    input  logic [PW-1:0]                  mid,
    input  logic [PW-1:0]                  pix,
    input  logic [wmtd_pkg::THR_W-1:0]     threshold,
    output logic                           is_star
);

    localparam int SW = PW + 4;
    localparam int TW = wmtd_pkg::THR_W + 4;
    localparam int CMP_W = (SW > TW) ? SW : TW;

    // Cells 0..2 are the older column (top, middle, bottom), 3..5 the newer one.
    logic [PW-1:0] cell_reg  [6];
    logic [PW-1:0] cell_next [6];
    logic [SW-1:0] sum;
    logic [TW-1:0] limit;

    always_comb
    begin
        sum = SW'(top) + SW'(mid) + SW'(pix);
        for (int k = 0; k < 6; k++)
        begin
            sum = sum + SW'(cell_reg[k]);
        end
    end

    // Nine times the threshold, built from a shift and an add.
    assign limit   = TW'({threshold, 3'b000}) + TW'(threshold);
    assign is_star = CMP_W'(sum) > CMP_W'(limit);

    always_comb
    begin
        cell_next[0] = cell_reg[3];
        cell_next[1] = cell_reg[4];
        cell_next[2] = cell_reg[5];
        cell_next[3] = top;
        cell_next[4] = mid;
        cell_next[5] = pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                cell_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < 6; k++)
            begin
                cell_reg[k] <= cell_next[k];
            end
        end
    end

endmodule

// ===== design/window_mean_threshold_detector_unit.sv =====
// Star detector over a 3x3 box mean of a raster-order brightness stream.
// Pixel items arrive on pixel_valid/pixel_stall with one brightness sample
// each; results leave on result_valid/result_stall with is_star, end_of_row
// and end_of_frame. Only interior cells give a result, so the first two rows
// and the first two columns of each row are absorbed without output.
// An accepted pixel goes to a stage register while both line memories are
// read at its column; when the stage advances, the window sum and the compare
// load the output register, from which the result is offered.
// One pixel is accepted in every unstalled cycle; the single read and write
// port of each line memory and the one-column window shift set that rate.
// When the receiver stalls, the result holds in the output register, the
// stage register holds the next item, and pixel_stall rises only once both
// are full. Reset clears the counters, the window and the registers to
// threshold 10, 10 rows and 30 columns; the line memories are not cleared,
// which is harmless since every entry is written before it is used.
// The configuration port writes a register at any edge with cfg_write high;
// a size write restarts the frame at row zero, column zero.
module window_mean_threshold_detector_unit #(
    parameter int MAX_COLS   = wmtd_pkg::MAX_COLS_DEFAULT,
    parameter int PIXEL_BITS = wmtd_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [wmtd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wmtd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  logic [wmtd_pkg::IN_PIX_W-1:0]      brightness,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               is_star,
    output logic                               end_of_row,
    output logic                               end_of_frame
);

    // Columns beyond the frame limit are never used, so the memories stop there.
    localparam int DEPTH = (MAX_COLS < wmtd_pkg::LIMIT_POS) ? MAX_COLS : wmtd_pkg::LIMIT_POS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PIXEL_BITS < wmtd_pkg::IN_PIX_W) ? PIXEL_BITS : wmtd_pkg::IN_PIX_W;

    logic                       accept;
    logic                       s1_adv;
    logic [AW-1:0]              col_addr;
    wmtd_pkg::scan_info_t       info;
    logic [wmtd_pkg::THR_W-1:0] threshold;
    logic [PW-1:0]              above_data;
    logic [PW-1:0]              two_above_data;
    logic                       star;

    logic                       s1_valid_reg, s1_valid_next;
    logic [PW-1:0]              s1_pix_reg;
    logic [AW-1:0]              s1_addr_reg;
    wmtd_pkg::scan_info_t       s1_info_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_star_reg;
    logic                       out_row_reg;
    logic                       out_frame_reg;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign pixel_stall = s1_valid_reg && !s1_adv;
    assign accept      = pixel_valid && !pixel_stall;

    wmtd_scan #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col_addr  (col_addr),
        .info      (info),
        .threshold (threshold)
    );

    // The row above gets the new pixel; the row two above gets what was above.
    wmtd_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PW)
    ) u_above (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_addr),
        .rd_data (above_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg)
    );

    wmtd_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PW)
    ) u_two_above (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_addr),
        .rd_data (two_above_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (above_data)
    );

    wmtd_window #(
        .PW (PW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .top       (two_above_data),
        .mid       (above_data),
        .pix       (s1_pix_reg),
        .threshold (threshold),
        .is_star   (star)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_info_reg.produce;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= brightness[PW-1:0];
            s1_addr_reg <= col_addr;
            s1_info_reg <= info;
        end
        if (s1_adv)
        begin
            out_star_reg  <= star;
            out_row_reg   <= s1_info_reg.row_end;
            out_frame_reg <= s1_info_reg.frame_end;
        end
    end

    assign result_valid = out_valid_reg;
    assign is_star      = out_star_reg;
    assign end_of_row   = out_row_reg;
    assign end_of_frame = out_frame_reg;

    // The last result of a frame is always the last one of its row.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!end_of_frame || end_of_row))
        else $error("frame end without row end");

    // Input is held back only while the stage register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> s1_valid_reg)
        else $error("pixel stalled with empty stage");

    // An accepted item always lands in the stage register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> s1_valid_reg)
        else $error("accepted item lost");

endmodule
